FILE: src/cis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types and constants for the compacting id set and its cells.
// ----------------------------------------------------------------------------
package cis_pkg;

  // fixed field widths of the request and result beats
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  // request kinds, the unused code behaves as a check
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_e;

  // request sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;    // compare the stored entry against the key
    logic shift;  // take the entry of the upper neighbor
    logic load;   // store the key
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/compacting_id_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_id_set
// Packed set of distinct ids in arrival order, held in a row of cells.
// ----------------------------------------------------------------------------
// Each request beat (add, remove or check) is taken one at a time. After
// acceptance every cell compares its entry with the id in parallel and
// registers the hit; in the next cycle a prefix OR over the hit
// vector selects the cells that take their upper neighbor's entry on a
// remove, the slot is encoded and the result is loaded into the output
// register. The result beat is registered, and the block takes no new
// request until the current one has passed its accept, compare and commit
// steps while results are taken; a stalled result holds the commit step.
// The store is empty right after reset, with no clearing pass.
module compacting_id_set #(
  parameter int CAPACITY = 64,
  parameter int ID_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cis_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [ID_WIDTH-1:0]          id_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              found_o,
  output logic      [cis_pkg::SLOT_W-1:0]   slot_o,
  output logic      [cis_pkg::COUNT_W-1:0]  count_o,
  output logic                              full_drop_o
);

  localparam int SW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LV = $clog2(CAPACITY);

  cis_pkg::state_e state_q, state_d;
  cis_pkg::kind_e  kind_q;
  logic [ID_WIDTH-1:0] key_q;
  logic [CW-1:0]       count_q, count_d;

  logic out_valid_q;
  logic found_q, drop_q;
  logic [cis_pkg::SLOT_W-1:0]  slot_q;
  logic [cis_pkg::COUNT_W-1:0] cnt_out_q;

  logic accept, cmp_en, commit;

  logic [ID_WIDTH-1:0]     entry_w [CAPACITY];
  logic [CAPACITY-1:0]     match_w;
  logic [CAPACITY-1:0]     pre [LV+1];
  cis_pkg::cell_ctrl_t     ctrl_w [CAPACITY];

  logic          found, key_empty, has_room, do_add, do_remove, drop;
  logic [SW-1:0] idx;
  logic [SW-1:0] slot_res;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cis_pkg::S_IDLE: if (in_valid_i) state_d = cis_pkg::S_CMP;
      cis_pkg::S_CMP:  state_d = cis_pkg::S_UPD;
      cis_pkg::S_UPD:  if (!out_valid_q || out_ready_i) state_d = cis_pkg::S_IDLE;
      default:         state_d = cis_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmp_en     = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      cis_pkg::S_IDLE: in_ready_o = 1'b1;
      cis_pkg::S_CMP:  cmp_en     = 1'b1;
      cis_pkg::S_UPD:  commit     = !out_valid_q || out_ready_i;
      default:         in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cis_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= cis_pkg::kind_e'(kind_i);
      key_q  <= id_i;
    end
  end

  // prefix or of the hit vector: cells at and above the hit shift down
  always_comb begin
    pre[0] = match_w;
    for (int l = 0; l < LV; l++) begin
      pre[l+1] = pre[l] | (pre[l] << (1 << l));
    end
  end

  // slot of the single hit
  always_comb begin
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      idx = idx | (match_w[i] ? SW'(i) : SW'(0));
    end
  end

  // request decode and result
  always_comb begin
    found     = |match_w;
    key_empty = (key_q == {ID_WIDTH{1'b1}});
    has_room  = (count_q != CW'(CAPACITY));
    do_add    = 1'b0;
    do_remove = 1'b0;
    drop      = 1'b0;
    slot_res  = found ? idx : SW'(0);
    count_d   = count_q;
    unique case (kind_q)
      cis_pkg::KIND_ADD: begin
        if (!found && !key_empty) begin
          if (has_room) begin
            do_add   = 1'b1;
            slot_res = SW'(count_q);
            count_d  = count_q + CW'(1);
          end else begin
            drop = 1'b1;
          end
        end
      end
      cis_pkg::KIND_REMOVE: begin
        if (found) begin
          do_remove = 1'b1;
          count_d   = count_q - CW'(1);
        end
      end
      default: begin
        do_add = 1'b0;
      end
    endcase
  end

  // stored count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= count_d;
    end
  end

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_WIDTH-1:0] next_w;

    if (g == CAPACITY - 1) begin : g_top
      assign next_w = {ID_WIDTH{1'b1}};
    end else begin : g_mid
      assign next_w = entry_w[g+1];
    end

    assign ctrl_w[g].cmp   = cmp_en;
    assign ctrl_w[g].shift = commit && do_remove && pre[LV][g];
    assign ctrl_w[g].load  = commit && do_add && (count_q == CW'(g));

    cis_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_w[g]),
      .key_i  (key_q),
      .next_i (next_w),
      .entry_o(entry_w[g]),
      .match_o(match_w[g])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      found_q   <= found;
      slot_q    <= cis_pkg::SLOT_W'(slot_res);
      cnt_out_q <= cis_pkg::COUNT_W'(count_d);
      drop_q    <= drop;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign slot_o      = slot_q;
  assign count_o     = cnt_out_q;
  assign full_drop_o = drop_q;

`ifndef SYNTHESIS
  // stored ids are distinct, so at most one cell hits
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cis_pkg::S_UPD) |-> $onehot0(match_w))
    else $error("more than one cell matched the key");

  // count never passes the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  // the top cell is empty unless the store is full
  a_top_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CW'(CAPACITY)) |-> (entry_w[CAPACITY-1] == {ID_WIDTH{1'b1}}))
    else $error("top cell holds an id while store is not full");

  // a successful remove lowers the count by one
  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && do_remove) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("remove did not decrement count");
`endif

endmodule
`default_nettype wire

FILE: src/cis_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cis_cell
// One slot of the id set: holds an entry, compares it against the broadcast
// key and hands it down to its lower neighbor on compaction.
// ----------------------------------------------------------------------------
module cis_cell #(
  parameter int ID_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cis_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [ID_WIDTH-1:0]  key_i,
  input  wire logic [ID_WIDTH-1:0]  next_i,
  output logic      [ID_WIDTH-1:0]  entry_o,
  output logic                      match_o
);

  logic [ID_WIDTH-1:0] entry_q;
  logic                match_q;
  logic                hit;

  // the empty marker never matches
  assign hit = (entry_q == key_i) && (key_i != {ID_WIDTH{1'b1}});

  // stored entry, empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= {ID_WIDTH{1'b1}};
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end else if (ctrl_i.load) begin
      entry_q <= key_i;
    end
  end

  // registered compare result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= hit;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule
`default_nettype wire
